FILE: hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants, types and the CRC-8 byte step for the lidar deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned POINTS_PER_PACKET = 12;

  localparam logic [7:0]  HEADER_BYTE = 8'h54;
  localparam logic [7:0]  CRC_POLY    = 8'h4D;
  localparam int unsigned FULL_TURN   = 36000;

  // Byte positions inside a packet
  localparam int unsigned START_POS  = 4;
  localparam int unsigned POINTS_POS = 6;
  localparam int unsigned END_POS    = POINTS_POS + 3 * POINTS_PER_PACKET;
  localparam int unsigned STAMP_POS  = END_POS + 2;
  localparam int unsigned CRC_POS    = STAMP_POS + 2;

  localparam int unsigned COUNT_W = $clog2(CRC_POS + 1);
  localparam int unsigned ADDR_W  = $clog2(CRC_POS);
  localparam int unsigned IDX_W   = $clog2(POINTS_PER_PACKET);
  localparam int unsigned PIDX_W  = 4;
  localparam int unsigned ANGLE_W = 21;
  // span kept at angle width so a negative span wraps like the angle
  localparam int unsigned SPAN_W  = ANGLE_W;

  typedef enum logic [2:0] {
    S_HUNT,
    S_COLLECT,
    S_RD0,
    S_RD1,
    S_RD2,
    S_PUSH
  } lpd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic store_byte;  // write byte, advance CRC and count
    logic end_pkt;     // CRC byte taken: clear count/CRC, set up point loop
    logic rd_en;       // read packet store, advance read address
    logic cap_lo;      // distance low byte on read data
    logic cap_hi;      // distance high byte on read data
    logic push;        // load output register with next point
  } lpd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hdr_match;
    logic at_crc;
    logic crc_ok;
    logic last_pt;
    logic out_free;
  } lpd_sts_t;

  // CRC-8, poly 0x4D, MSB first; argument is crc ^ byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] v);
    logic [7:0] c;
    c = v;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/lpd_ram.sv
// ----------------------------------------------------------------------------
// lpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 46
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/lpd_dp.sv
// ----------------------------------------------------------------------------
// lpd_dp
// Datapath: byte count, running CRC, header words, packet store, angle
// accumulator and the output register.
// ----------------------------------------------------------------------------
module lpd_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_byte,
  input  lpd_pkg::lpd_cmd_t     cmd,
  output lpd_pkg::lpd_sts_t     sts,
  input  logic                  out_tready,
  output logic                  out_valid,
  output logic [3:0]            out_point_index,
  output logic [20:0]           out_angle_scaled,
  output logic [15:0]           out_distance_mm,
  output logic [7:0]            out_confidence,
  output logic [15:0]           out_time_stamp,
  output logic                  out_last_point
);

  import lpd_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [15:0]        start_r, end_r, stamp_r;
  logic [7:0]         dist_lo_r;
  logic [15:0]        dist_r;
  logic [SPAN_W-1:0]  span_r;
  logic [ANGLE_W-1:0] acc_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic [7:0]         rd_data;

  logic [SPAN_W-1:0]  span_w;
  logic [ANGLE_W-1:0] base_w;

  logic [PIDX_W-1:0]  o_idx_r;
  logic [ANGLE_W-1:0] o_angle_r;
  logic [15:0]        o_dist_r;
  logic [7:0]         o_conf_r;
  logic [15:0]        o_stamp_r;
  logic               o_last_r;

  lpd_ram #(
    .WIDTH (8),
    .DEPTH (CRC_POS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store_byte),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (in_byte),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // wrap past end angle by a full turn; a negative result wraps mod 2^21
  always_comb begin
    if (end_r >= start_r) begin
      span_w = SPAN_W'(end_r) - SPAN_W'(start_r);
    end else begin
      span_w = SPAN_W'(end_r) + SPAN_W'(FULL_TURN) - SPAN_W'(start_r);
    end
    base_w = ANGLE_W'(start_r) * ANGLE_W'(POINTS_PER_PACKET - 1);
  end

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    if (cmd.end_pkt) begin
      count_nxt = '0;
      crc_nxt   = '0;
    end else if (cmd.store_byte) begin
      count_nxt = count_r + COUNT_W'(1);
      crc_nxt   = crc8_byte(crc_r ^ in_byte);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // header word capture
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      if (count_r == COUNT_W'(START_POS))     start_r[7:0]  <= in_byte;
      if (count_r == COUNT_W'(START_POS + 1)) start_r[15:8] <= in_byte;
      if (count_r == COUNT_W'(END_POS))       end_r[7:0]    <= in_byte;
      if (count_r == COUNT_W'(END_POS + 1))   end_r[15:8]   <= in_byte;
      if (count_r == COUNT_W'(STAMP_POS))     stamp_r[7:0]  <= in_byte;
      if (count_r == COUNT_W'(STAMP_POS + 1)) stamp_r[15:8] <= in_byte;
    end
  end

  // point loop
  always_ff @(posedge clk) begin
    if (cmd.end_pkt) begin
      span_r    <= span_w;
      acc_r     <= base_w;
      idx_r     <= '0;
      rd_addr_r <= ADDR_W'(POINTS_POS);
    end else begin
      if (cmd.rd_en) begin
        rd_addr_r <= rd_addr_r + ADDR_W'(1);
      end
      if (cmd.push) begin
        acc_r <= acc_r + ANGLE_W'(span_r);
        idx_r <= idx_r + IDX_W'(1);
      end
    end
    if (cmd.cap_lo) dist_lo_r <= rd_data;
    if (cmd.cap_hi) dist_r    <= {rd_data, dist_lo_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      o_idx_r   <= PIDX_W'(idx_r);
      o_angle_r <= acc_r;
      o_dist_r  <= dist_r;
      o_conf_r  <= rd_data;
      o_stamp_r <= stamp_r;
      o_last_r  <= (idx_r == IDX_W'(POINTS_PER_PACKET - 1));
    end
  end

  assign sts.hdr_match = (in_byte == HEADER_BYTE);
  assign sts.at_crc    = (count_r == COUNT_W'(CRC_POS));
  assign sts.crc_ok    = (in_byte == crc_r);
  assign sts.last_pt   = (idx_r == IDX_W'(POINTS_PER_PACKET - 1));
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_valid        = out_valid_r;
  assign out_point_index  = o_idx_r;
  assign out_angle_scaled = o_angle_r;
  assign out_distance_mm  = o_dist_r;
  assign out_confidence   = o_conf_r;
  assign out_time_stamp   = o_stamp_r;
  assign out_last_point   = o_last_r;

endmodule

FILE: hw/rtl/lpd_ctrl.sv
// ----------------------------------------------------------------------------
// lpd_ctrl
// Controller: header hunt, packet collection and per-point read sequence.
// ----------------------------------------------------------------------------
module lpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  lpd_pkg::lpd_sts_t sts,
  output lpd_pkg::lpd_cmd_t cmd
);

  import lpd_pkg::*;

  lpd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_HUNT: begin
        if (in_tvalid && sts.hdr_match) state_nxt = S_COLLECT;
      end
      S_COLLECT: begin
        if (in_tvalid && sts.at_crc) begin
          state_nxt = sts.crc_ok ? S_RD0 : S_HUNT;
        end
      end
      S_RD0: state_nxt = S_RD1;
      S_RD1: state_nxt = S_RD2;
      S_RD2: state_nxt = S_PUSH;
      S_PUSH: begin
        if (sts.out_free) state_nxt = sts.last_pt ? S_HUNT : S_RD0;
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_HUNT: begin
        cmd.in_ready   = 1'b1;
        cmd.store_byte = in_tvalid && sts.hdr_match;
      end
      S_COLLECT: begin
        cmd.in_ready   = 1'b1;
        cmd.store_byte = in_tvalid && !sts.at_crc;
        cmd.end_pkt    = in_tvalid && sts.at_crc;
      end
      S_RD0: cmd.rd_en = 1'b1;
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.cap_lo = 1'b1;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.cap_hi = 1'b1;
      end
      S_PUSH: cmd.push = sts.out_free;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_no_input_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD0 || state_r == S_RD1 || state_r == S_RD2 || state_r == S_PUSH)
    |-> !cmd.in_ready)
    else $error("input taken during point readout");

  a_bad_crc_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COLLECT && in_tvalid && sts.at_crc && !sts.crc_ok)
    |=> (state_r == S_HUNT))
    else $error("bad CRC packet not dropped");

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("output register overwritten");

  a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && sts.last_pt) |=> (state_r == S_HUNT))
    else $error("readout continues past last point");
`endif

endmodule

FILE: hw/rtl/lidar_packet_deframer_crc8.sv
// ----------------------------------------------------------------------------
// lidar_packet_deframer_crc8
// Deframes lidar scan packets from a byte stream, checks CRC-8, emits points.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while hunting and collecting a packet.
// After a good CRC byte the input stalls while the 12 points are read out, in
// four steps each (three reads through the single read port of the packet
// store plus the output load), and longer while the result side stalls.
// The first point enters the output register in S_PUSH, after S_RD0 to S_RD2.
// Reset: synchronous, active low; clears FSM, byte count, CRC and output valid.
// The packet store is not cleared; every entry read was written in the packet.
// ----------------------------------------------------------------------------
module lidar_packet_deframer_crc8 (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [3:0] point_index, [24:4] angle_scaled,
                                  // [40:25] distance_mm, [48:41] confidence,
                                  // [64:49] time_stamp, [71:65] zero
  output logic        out_tlast   // last_point
);

  import lpd_pkg::*;

  lpd_cmd_t cmd;
  lpd_sts_t sts;

  logic [3:0]  point_index;
  logic [20:0] angle_scaled;
  logic [15:0] distance_mm;
  logic [7:0]  confidence;
  logic [15:0] time_stamp;

  // Sequencer: hunt for header, collect bytes, then walk the points.
  lpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: CRC, packet store, angle accumulator, output register.
  // The output register decouples the result side from the readout loop.
  lpd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_tdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_tready       (out_tready),
    .out_valid        (out_tvalid),
    .out_point_index  (point_index),
    .out_angle_scaled (angle_scaled),
    .out_distance_mm  (distance_mm),
    .out_confidence   (confidence),
    .out_time_stamp   (time_stamp),
    .out_last_point   (out_tlast)
  );

  assign in_tready = cmd.in_ready;

  assign out_tdata = {7'd0, time_stamp, confidence, distance_mm, angle_scaled, point_index};

endmodule

FILE: tb/lpd_point_checker.sv
// ----------------------------------------------------------------------------
// lpd_point_checker
// Watches both streams of the lidar deframer, predicts every point and
// compares each output transfer with the oldest predicted point.
// ----------------------------------------------------------------------------
module lpd_point_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatches,
  output int          points_pending
);
  import lpd_pkg::*;

  typedef struct packed {
    logic [3:0]  idx;
    logic [20:0] angle;
    logic [15:0] dist_mm;
    logic [7:0]  conf;
    logic [15:0] stamp;
    logic        last;
  } point_t;

  point_t      point_q[$];
  logic        hunt;
  int unsigned nbytes;
  logic [7:0]  crc_acc;
  logic [7:0]  pkt_bytes [0:CRC_POS-1];
  int          fail_cnt;

  // MSB-first CRC-8 over one byte
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = (c << 1) ^ CRC_POLY;
      else      c = c << 1;
    end
    return c;
  endfunction

  function automatic logic [15:0] word_le(input int unsigned pos);
    return {pkt_bytes[pos+1], pkt_bytes[pos]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_cnt++;
    if (fail_cnt <= 40)
      $display("ERROR @%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endtask

  // advance the deframer prediction by one accepted byte
  task automatic take_byte(input logic [7:0] b);
    logic [31:0] start_w;
    logic [31:0] stop_w;
    logic [31:0] span;
    logic [31:0] angle;
    int unsigned p;
    point_t      pt;
    if (hunt) begin
      if (b == HEADER_BYTE) begin
        pkt_bytes[0] = b;
        crc_acc = crc8_next(8'h00, b);
        nbytes = 1;
        hunt = 1'b0;
      end
    end else if (nbytes < CRC_POS) begin
      pkt_bytes[nbytes] = b;
      crc_acc = crc8_next(crc_acc, b);
      nbytes++;
    end else begin
      // CRC byte: drop silently on mismatch, emit all points on match
      hunt = 1'b1;
      nbytes = 0;
      if (b == crc_acc) begin
        start_w = 32'(word_le(START_POS));
        stop_w  = 32'(word_le(END_POS));
        // negative span wraps; only the low 21 bits of the angle survive
        span = (stop_w >= start_w) ? stop_w - start_w : stop_w + FULL_TURN - start_w;
        for (int i = 0; i < POINTS_PER_PACKET; i++) begin
          p = POINTS_POS + 3 * i;
          angle = (POINTS_PER_PACKET - 1) * start_w + i * span;
          pt.idx     = 4'(i);
          pt.angle   = angle[20:0];
          pt.dist_mm = word_le(p);
          pt.conf    = pkt_bytes[p+2];
          pt.stamp   = word_le(STAMP_POS);
          pt.last    = (i == POINTS_PER_PACKET - 1);
          point_q = {point_q, pt};
        end
      end
      crc_acc = 8'h00;
    end
  endtask

  task automatic check_point(input logic [71:0] d, input logic tl);
    point_t want;
    if (point_q.size() == 0) begin
      report_mismatch("unexpected point, index", 32'd0, 32'(d[3:0]));
    end else begin
      want = point_q.pop_front();
      if (d[3:0] !== want.idx)
        report_mismatch("point_index", 32'(want.idx), 32'(d[3:0]));
      if (d[24:4] !== want.angle)
        report_mismatch("angle_scaled", 32'(want.angle), 32'(d[24:4]));
      if (d[40:25] !== want.dist_mm)
        report_mismatch("distance_mm", 32'(want.dist_mm), 32'(d[40:25]));
      if (d[48:41] !== want.conf)
        report_mismatch("confidence", 32'(want.conf), 32'(d[48:41]));
      if (d[64:49] !== want.stamp)
        report_mismatch("time_stamp", 32'(want.stamp), 32'(d[64:49]));
      if (tl !== want.last)
        report_mismatch("last_point", 32'(want.last), 32'(tl));
      if (d[71:65] !== 7'd0)
        report_mismatch("tdata padding", 32'd0, 32'(d[71:65]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hunt = 1'b1;
      nbytes = 0;
      crc_acc = 8'h00;
      point_q.delete();
      fail_cnt = 0;
    end else begin
      if (out_tvalid && out_tready) check_point(out_tdata, out_tlast);
      if (in_tvalid && in_tready) take_byte(in_tdata);
    end
    // published after the edge so readers never race the update
    mismatches     <= fail_cnt;
    points_pending <= point_q.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives lidar scan packets (good, bad CRC, cut short) and line noise into the
// deframer with bursty input and a stalling output, and lets the point
// checker score every point.
// ----------------------------------------------------------------------------
module testbench;
  import lpd_pkg::*;

  typedef enum int {ACT_NOISE, ACT_BAD_CRC, ACT_CUT, ACT_DRAIN, ACT_GOOD} act_t;
  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_BURSTY} rdy_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  int          mismatches;
  int          points_pending;

  // sender burst bookkeeping
  int          burst_left = 0;
  int          sent_bytes = 0;

  // receiver stall pattern
  rdy_mode_t   rdy_mode = RDY_ALWAYS;
  int          rdy_phase = 0;
  int          rdy_hold = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lidar_packet_deframer_crc8 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // point_index, angle_scaled, distance_mm,
                               // confidence, time_stamp, zero pad
    .out_tlast  (out_tlast)    // last_point
  );

  lpd_point_checker point_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .points_pending (points_pending)
  );

  // Receiver: picks a new stall pattern at the end of each phase. Always-ready
  // phases give stretches with no backpressure; bursty mode toggles tready
  // after a random hold, long enough to back up into the input.
  always @(posedge clk) begin
    if (rdy_phase == 0) begin
      rdy_mode  <= rdy_mode_t'($urandom_range(0, 3));
      rdy_phase <= 63;
    end else begin
      rdy_phase <= rdy_phase - 1;
    end
    case (rdy_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rdy_hold == 0) begin
          rdy_hold   <= $urandom_range(1, 12);
          out_tready <= ~out_tready;
        end else begin
          rdy_hold <= rdy_hold - 1;
        end
      end
    endcase
  end

  // One byte transfer. At the start of each burst the sender may drop tvalid
  // for a random gap; a quarter of the bursts follow the previous one with no gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent_bytes++;
  endtask

  // Hold off the input until the last predicted point has left the block.
  task automatic drain_points();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Builds one scan packet and sends its first n_send bytes. Point bytes are
  // either a constant fill or random; bad_crc flips one bit of the CRC byte.
  task automatic send_packet(input logic [15:0] start_w, input logic [15:0] stop_w,
                             input logic [15:0] stamp_w, input logic [7:0] fill,
                             input bit rand_fill, input bit bad_crc, input int n_send);
    logic [7:0] pkt [0:CRC_POS];
    logic [7:0] crc;
    pkt[0] = HEADER_BYTE;
    pkt[1] = 8'($urandom);
    pkt[2] = 8'($urandom);
    pkt[3] = 8'($urandom);
    pkt[START_POS]     = start_w[7:0];
    pkt[START_POS + 1] = start_w[15:8];
    for (int k = POINTS_POS; k < END_POS; k++) pkt[k] = rand_fill ? 8'($urandom) : fill;
    pkt[END_POS]       = stop_w[7:0];
    pkt[END_POS + 1]   = stop_w[15:8];
    pkt[STAMP_POS]     = stamp_w[7:0];
    pkt[STAMP_POS + 1] = stamp_w[15:8];
    crc = 8'h00;
    for (int k = 0; k < CRC_POS; k++) crc = crc8_byte(crc ^ pkt[k]);
    pkt[CRC_POS] = bad_crc ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc;
    for (int k = 0; k < n_send; k++) send_byte(pkt[k]);
  endtask

  initial begin
    act_t        act;
    int          r;
    logic [7:0]  b;
    logic [15:0] start_w;
    logic [15:0] stop_w;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // noise while hunting must be ignored
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HEADER_BYTE - 8'd1);
    send_byte(HEADER_BYTE + 8'd1);
    // end angle below start: span crosses a full turn; header bytes as data
    send_packet(16'd35999, 16'd100, 16'h1234, HEADER_BYTE, 1'b0, 1'b0, CRC_POS + 1);
    // maximum start, end far below: span goes negative, angle wraps to 21 bits
    send_packet(16'hFFFF, 16'd0, 16'h5A3C, 8'h00, 1'b1, 1'b0, CRC_POS + 1);
    // bad CRC, then a good packet right behind it
    send_packet(16'd1000, 16'd2000, 16'h0001, HEADER_BYTE, 1'b0, 1'b1, CRC_POS + 1);
    send_packet(16'd1000, 16'd2000, 16'h0002, 8'h00, 1'b1, 1'b0, CRC_POS + 1);
    drain_points();

    // --- random part, until the byte budget is spent ---
    while (sent_bytes < 260) begin
      r = $urandom_range(0, 9);
      act = (r == 0) ? ACT_NOISE : (r == 1) ? ACT_BAD_CRC : (r == 2) ? ACT_CUT :
            (r == 3) ? ACT_DRAIN : ACT_GOOD;
      start_w = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
      stop_w  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
      case (act)
        ACT_NOISE: begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom);
            if (b == HEADER_BYTE) b = ~b;
            send_byte(b);
          end
        end
        ACT_BAD_CRC: begin
          send_packet(start_w, stop_w, 16'($urandom), 8'h00, 1'b1, 1'b1, CRC_POS + 1);
        end
        ACT_CUT: begin
          // packet cut short; whatever follows is absorbed into it
          r = $urandom_range(1, CRC_POS - 1);
          send_packet(start_w, stop_w, 16'($urandom), 8'h00, 1'b1, 1'b0, r);
        end
        ACT_DRAIN: drain_points();
        default: begin
          send_packet(start_w, stop_w, 16'($urandom), 8'h00, 1'b1, 1'b0, CRC_POS + 1);
        end
      endcase
    end

    // wait out the last points, then give stray outputs a chance to show
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0 && points_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
